### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// The condition implies the consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg
// Types, codes and rounding helpers shared by the fp32 matrix multiply core.
// ----------------------------------------------------------------------------
package mmf_pkg;

  // Command codes. The last code is not used and the core ignores it.
  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [1:0] REG_COL_COUNT   = 2'd2;

  // Default quiet NaN produced by invalid operations.
  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] product_value;
    logic        index_error;
  } result_t;

  // Tag carried alongside each step through the arithmetic units.
  typedef struct packed {
    logic first;
    logic last;
  } tag_t;

  // Leading zero count of a 24-bit significand.
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (v[i] && !found) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zero count of a 28-bit sum; a zero sum gives 27.
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (v[i] && !found) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. The significand m has its leading one at
  // bit 47 and be is the biased exponent of that bit; subnormal and overflow
  // results are handled here.
  function automatic logic [31:0] fp_round(input logic sign,
                                           input logic signed [11:0] be,
                                           input logic [47:0] m);
    logic [47:0] t;
    logic [5:0]  sh;
    logic [23:0] sig;
    logic        g;
    logic        st;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] mag;
    t = m;
    sh = 6'd0;
    sig = m[47:24];
    g = m[23];
    st = |m[22:0];
    ef = be[7:0];
    if (be <= 12'sd0) begin
      sh = (be < -12'sd25) ? 6'd26 : 6'(12'sd1 - be);
      t = m >> sh;
      sig = t[47:24];
      g = t[23];
      st = (|t[22:0]) | ((t << sh) != m);
      ef = 8'd0;
    end
    inc = g & (st | sig[0]);
    mag = {ef, sig[22:0]} + 31'(inc);
    if (be >= 12'sd255) begin
      mag = {8'hFF, 23'd0};
    end
    return {sign, mag};
  endfunction

endpackage

### rtl/mmf_fmul.sv
// ----------------------------------------------------------------------------
// mmf_fmul
// Three-stage fp32 multiplier: unpack and normalize, multiply, round.
// ----------------------------------------------------------------------------
module mmf_fmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  mmf_pkg::tag_t in_tag,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output logic          out_valid,
  output mmf_pkg::tag_t out_tag,
  output logic [31:0]   res
);

  // Operand classification and input normalization.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [4:0]  lza, lzb;
  logic        spec;
  logic [31:0] spec_val;
  logic        sign;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    lza    = mmf_pkg::lzc24(ma);
    lzb    = mmf_pkg::lzc24(mb);
    sign   = a[31] ^ b[31];
    spec   = 1'b1;
    if (a_nan) begin
      spec_val = a | 32'h0040_0000;
    end else if (b_nan) begin
      spec_val = b | 32'h0040_0000;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_val = mmf_pkg::FP_DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      spec_val = {sign, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_val = {sign, 31'd0};
    end else begin
      spec = 1'b0;
      spec_val = 32'd0;
    end
  end

  // Stage registers.
  logic                 s0_valid, s1_valid;
  mmf_pkg::tag_t        s0_tag, s1_tag;
  logic [23:0]          s0_ma, s0_mb;
  logic signed [9:0]    s0_ea, s0_eb;
  logic                 s0_sign, s1_sign;
  logic                 s0_spec, s1_spec;
  logic [31:0]          s0_spec_val, s1_spec_val;
  logic [47:0]          s1_prod;
  logic signed [11:0]   s1_esum;
  logic [47:0]          norm_m;
  logic signed [11:0]   norm_be;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      out_valid <= s1_valid;
    end
  end

  always_comb begin
    norm_be = s1_esum + 12'(s1_prod[47]);
    norm_m  = s1_prod[47] ? s1_prod : (s1_prod << 1);
  end

  // Payload pipeline.
  always_ff @(posedge clk) begin
    s0_tag      <= in_tag;
    s0_ma       <= ma << lza;
    s0_mb       <= mb << lzb;
    s0_ea       <= 10'((a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, a[30:23]})) -
                   $signed({5'd0, lza});
    s0_eb       <= 10'((b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b[30:23]})) -
                   $signed({5'd0, lzb});
    s0_sign     <= sign;
    s0_spec     <= spec;
    s0_spec_val <= spec_val;

    s1_tag      <= s0_tag;
    s1_prod     <= s0_ma * s0_mb;
    s1_esum     <= 12'(s0_ea) + 12'(s0_eb) - 12'sd127;
    s1_sign     <= s0_sign;
    s1_spec     <= s0_spec;
    s1_spec_val <= s0_spec_val;

    if (s1_valid) begin
      out_tag <= s1_tag;
      res     <= s1_spec ? s1_spec_val : mmf_pkg::fp_round(s1_sign, norm_be, norm_m);
    end
  end

endmodule

### rtl/mmf_fadd.sv
// ----------------------------------------------------------------------------
// mmf_fadd
// Three-stage fp32 adder: align, add, normalize and round.
// ----------------------------------------------------------------------------
module mmf_fadd (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  mmf_pkg::tag_t in_tag,
  input  logic [31:0]   x,
  input  logic [31:0]   y,
  output logic          out_valid,
  output mmf_pkg::tag_t out_tag,
  output logic [31:0]   res
);

  // Classification, ordering by magnitude and alignment.
  logic        x_nan, y_nan, x_inf, y_inf;
  logic        spec;
  logic [31:0] spec_val;
  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, diff;
  logic [4:0]  sh;
  logic [26:0] m_big, m_sml, m_al;

  always_comb begin
    x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    spec  = 1'b1;
    if (x_nan) begin
      spec_val = x | 32'h0040_0000;
    end else if (y_nan) begin
      spec_val = y | 32'h0040_0000;
    end else if (x_inf && y_inf && (x[31] != y[31])) begin
      spec_val = mmf_pkg::FP_DEFAULT_NAN;
    end else if (x_inf) begin
      spec_val = x;
    end else if (y_inf) begin
      spec_val = y;
    end else begin
      spec = 1'b0;
      spec_val = 32'd0;
    end
    swap  = y[30:0] > x[30:0];
    big   = swap ? y : x;
    sml   = swap ? x : y;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff  = e_big - e_sml;
    sh    = (diff > 8'd27) ? 5'd27 : diff[4:0];
    m_big = {big[30:23] != 8'd0, big[22:0], 3'b000};
    m_sml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    m_al  = m_sml >> sh;
    m_al[0] = m_al[0] | ((m_al << sh) != m_sml);
  end

  logic                 s0_valid, s1_valid;
  mmf_pkg::tag_t        s0_tag, s1_tag;
  logic [26:0]          s0_mb, s0_ms;
  logic [7:0]           s0_e, s1_e;
  logic                 s0_sign, s1_sign, s0_sub, s0_zsign, s1_zsign;
  logic                 s0_spec, s1_spec;
  logic [31:0]          s0_spec_val, s1_spec_val;
  logic [27:0]          s1_sum;
  logic [4:0]           lz;
  logic [47:0]          norm_m;
  logic signed [11:0]   norm_be;
  logic [31:0]          sum_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      out_valid <= s1_valid;
    end
  end

  // Normalize the raw sum and round it.
  always_comb begin
    lz      = mmf_pkg::lzc28(s1_sum);
    norm_m  = {s1_sum, 20'd0} << lz;
    norm_be = $signed({4'd0, s1_e}) + 12'sd1 - $signed({7'd0, lz});
    if (s1_spec) begin
      sum_res = s1_spec_val;
    end else if (s1_sum == 28'd0) begin
      sum_res = {s1_zsign, 31'd0};
    end else begin
      sum_res = mmf_pkg::fp_round(s1_sign, norm_be, norm_m);
    end
  end

  always_ff @(posedge clk) begin
    s0_tag      <= in_tag;
    s0_mb       <= m_big;
    s0_ms       <= m_al;
    s0_e        <= e_big;
    s0_sign     <= big[31];
    s0_sub      <= x[31] ^ y[31];
    s0_zsign    <= x[31] & y[31];
    s0_spec     <= spec;
    s0_spec_val <= spec_val;

    s1_tag      <= s0_tag;
    s1_sum      <= s0_sub ? ({1'b0, s0_mb} - {1'b0, s0_ms}) : ({1'b0, s0_mb} + {1'b0, s0_ms});
    s1_e        <= s0_e;
    s1_sign     <= s0_sign;
    s1_zsign    <= s0_zsign;
    s1_spec     <= s0_spec;
    s1_spec_val <= s0_spec_val;

    if (s1_valid) begin
      out_tag <= s1_tag;
      res     <= sum_res;
    end
  end

endmodule

### rtl/matrix_multiply_fp32_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_fp32_core
// Stores fp32 matrices A and B and returns single elements of C = A*B.
// ----------------------------------------------------------------------------
// A write of an A or B element is taken without raising busy. A read outside
// the configured sizes, or any read with an empty inner dimension, answers in
// the next cycle. Any other read runs K steps, K being the effective inner
// size, and fetches one element pair per step; a new pair is fetched only when
// its addition can take the previous sum from the three-stage adder. busy is
// high meanwhile. done is a one-cycle strobe and the receiver cannot stall it,
// so a result must be captured in the cycle it appears. Both stores are
// undefined until written.
module matrix_multiply_fp32_core #(
  parameter int MAX_ROWS  = 32,
  parameter int MAX_INNER = 32,
  parameter int MAX_COLS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mmf_pkg::cmd_t     cmd,
  output logic              done,
  output mmf_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  // Configuration registers.
  logic [5:0] row_count, inner_count, col_count;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 6'd32;
      inner_count <= 6'd32;
      col_count   <= 6'd32;
    end else if (cfg_write) begin
      case (paddr[3:2])
        mmf_pkg::REG_ROW_COUNT:   row_count   <= pwdata[5:0];
        mmf_pkg::REG_INNER_COUNT: inner_count <= pwdata[5:0];
        mmf_pkg::REG_COL_COUNT:   col_count   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mmf_pkg::REG_ROW_COUNT:   prdata = {26'd0, row_count};
      mmf_pkg::REG_INNER_COUNT: prdata = {26'd0, inner_count};
      mmf_pkg::REG_COL_COUNT:   prdata = {26'd0, col_count};
      default:                  prdata = 32'd0;
    endcase
  end

  // Effective sizes, limited by the store dimensions.
  logic [5:0] mm, kk, nn;
  assign mm = (int'(row_count)   > MAX_ROWS)  ? 6'(MAX_ROWS)  : row_count;
  assign kk = (int'(inner_count) > MAX_INNER) ? 6'(MAX_INNER) : inner_count;
  assign nn = (int'(col_count)   > MAX_COLS)  ? 6'(MAX_COLS)  : col_count;

  // Transaction decode.
  logic accept, wr_a, wr_b, rd_cmd, rd_bad;
  assign accept = start && !busy;
  assign wr_a   = accept && (cmd.op == mmf_pkg::OP_WRITE_A) &&
                  ({1'b0, cmd.row} < mm) && ({1'b0, cmd.col} < kk);
  assign wr_b   = accept && (cmd.op == mmf_pkg::OP_WRITE_B) &&
                  ({1'b0, cmd.row} < kk) && ({1'b0, cmd.col} < nn);
  assign rd_cmd = accept && (cmd.op == mmf_pkg::OP_READ);
  assign rd_bad = ({1'b0, cmd.row} >= mm) || ({1'b0, cmd.col} >= nn);

  // Sequencer registers.
  state_t        state;
  logic [4:0]    rd_row, rd_col;
  logic [5:0]    k_issue;
  logic [1:0]    phase;
  logic          issue;
  logic          fetch_valid;
  mmf_pkg::tag_t fetch_tag;

  assign busy  = (state == S_RUN);
  assign issue = (state == S_RUN) && (phase == 2'd0) && (k_issue < kk);

  // Element stores.
  logic [31:0] a_mem [A_DEPTH];
  logic [31:0] b_mem [B_DEPTH];
  logic [31:0] a_rd, b_rd;
  logic [A_AW-1:0] a_wr_addr, a_rd_addr;
  logic [B_AW-1:0] b_wr_addr, b_rd_addr;

  assign a_wr_addr = A_AW'(int'(cmd.row) * MAX_INNER + int'(cmd.col));
  assign b_wr_addr = B_AW'(int'(cmd.row) * MAX_COLS + int'(cmd.col));
  assign a_rd_addr = A_AW'(int'(rd_row) * MAX_INNER + int'(k_issue));
  assign b_rd_addr = B_AW'(int'(k_issue) * MAX_COLS + int'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[a_wr_addr] <= cmd.value;
    end
    if (wr_b) begin
      b_mem[b_wr_addr] <= cmd.value;
    end
    if (issue) begin
      a_rd <= a_mem[a_rd_addr];
      b_rd <= b_mem[b_rd_addr];
    end
  end

  // Shared multiply and add units.
  logic          mul_valid, add_valid;
  mmf_pkg::tag_t mul_tag, add_tag;
  logic [31:0]   mul_res, add_res;

  mmf_fmul u_fmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fetch_valid),
    .in_tag    (fetch_tag),
    .a         (a_rd),
    .b         (b_rd),
    .out_valid (mul_valid),
    .out_tag   (mul_tag),
    .res       (mul_res)
  );

  // The previous sum leaves the adder in the same cycle the next product leaves the multiplier.
  mmf_fadd u_fadd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_tag    (mul_tag),
    .x         (mul_tag.first ? 32'd0 : add_res),
    .y         (mul_res),
    .out_valid (add_valid),
    .out_tag   (add_tag),
    .res       (add_res)
  );

  // State, step counters and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      fetch_valid <= 1'b0;
      k_issue     <= 6'd0;
      phase       <= 2'd0;
    end else begin
      done        <= 1'b0;
      fetch_valid <= issue;
      case (state)
        S_IDLE: begin
          if (rd_cmd) begin
            rd_row  <= cmd.row;
            rd_col  <= cmd.col;
            k_issue <= 6'd0;
            phase   <= 2'd0;
            if (rd_bad || (kk == 6'd0)) begin
              done                 <= 1'b1;
              result.product_value <= 32'd0;
              result.index_error   <= rd_bad;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
          if (issue) begin
            k_issue         <= k_issue + 6'd1;
            fetch_tag.first <= (k_issue == 6'd0);
            fetch_tag.last  <= (k_issue == kk - 6'd1);
          end
          if (add_valid && add_tag.last) begin
            state                <= S_IDLE;
            done                 <= 1'b1;
            result.product_value <= add_res;
            result.index_error   <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mmf_checker.sv
// ----------------------------------------------------------------------------
// mmf_checker
// Port-level checks on the command and result transactions of the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmf_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input mmf_pkg::cmd_t    cmd,
  input logic             done,
  input mmf_pkg::result_t result
);

  // A result ends the work on its transaction.
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result shown while busy")

  // An error result carries zero.
  `ASSERT_SAME(a_err_zero, clk, rst, done && result.index_error,
               result.product_value == 32'd0, "error result is not zero")

  // An accepted read either starts work or answers at once.
  `ASSERT_NEXT(a_read_runs, clk, rst, start && !busy && (cmd.op == mmf_pkg::OP_READ),
               busy || done, "read transaction dropped")

  // Writes never produce a result.
  `ASSERT_NEXT(a_write_quiet, clk, rst, start && !busy && (cmd.op != mmf_pkg::OP_READ),
               !done, "write transaction produced a result")

endmodule

bind matrix_multiply_fp32_core mmf_checker u_mmf_checker (.*);
